>>> rtl/tspp_pkg.sv
// Shared types and constants of the trapezoidal step speed planner.
// Used by tspp_iter_unit and trapezoidal_step_speed_planner_unit; no dependencies.
package tspp_pkg;

    localparam int POSITION_BITS_DEF = 32;

    localparam logic [1:0] CMD_PLAN  = 2'd0;
    localparam logic [1:0] CMD_SPEED = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [1:0] REG_CRUISE = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;
    localparam logic [1:0] REG_ACCEL  = 2'd3;

    localparam logic [15:0] CRUISE_RST = 16'd1000;
    localparam logic [15:0] START_RST  = 16'd100;
    localparam logic [15:0] END_RST    = 16'd100;
    localparam logic [23:0] ACCEL_RST  = 24'd1000;
    localparam logic [31:0] SQ_RST     = 32'd10000;
    localparam logic [24:0] TWOA_RST   = 25'd2000;

    localparam logic [30:0] DIST_MAX       = 31'h7FFF_FFFF;
    localparam logic [30:0] MIN_STOP_STEPS = 31'd4;
    localparam logic [15:0] SPEED_MAX      = 16'hFFFF;

    localparam logic [5:0] DIV_STEPS  = 6'd32;
    localparam logic [5:0] SQRT_STEPS = 6'd16;

    typedef enum logic {
        IU_DIV,
        IU_SQRT
    } t_iu_op;

    typedef struct packed {
        logic        go;
        t_iu_op      op;
        logic [31:0] num;
        logic [24:0] den;
    } t_iu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] q;
    } t_iu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_SQ_END,
        ST_SQ_CRUISE,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_PLAN_END,
        ST_QSEL,
        ST_QMUL,
        ST_QADD,
        ST_SQ_WAIT,
        ST_STOP
    } t_state;

endpackage

>>> rtl/trapezoidal_step_speed_planner_unit.sv
// Top level of the trapezoidal step speed planner: command sequencer and datapath.
// Depends on tspp_pkg and tspp_iter_unit.
//
// One command is taken per beat when start is high and busy is low; busy stays
// high until the result strobe o_valid, which lasts exactly one cycle and cannot
// be held off. A plan runs two divisions in the shared divide/root unit, a speed
// query at most one multiply plus a square root; a stop and an undefined command
// use neither. Configuration writes take effect at once and are snapshotted by
// each plan.
module trapezoidal_step_speed_planner_unit #(
    parameter int POSITION_BITS = tspp_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_position,
    input  logic [31:0] i_target_position,
    output logic        o_valid,
    output logic [15:0] o_speed,
    output logic [30:0] o_stop_steps,
    output logic        o_bad_input
);

    tspp_pkg::t_state r_state, n_state;

    logic [15:0] r_cruise, r_start_spd, r_end_spd;
    logic [23:0] r_accel;

    logic [1:0]  r_cmd, n_cmd;
    logic [32:0] r_pos, n_pos;
    logic [32:0] r_tgt, n_tgt;

    logic [POSITION_BITS-1:0] r_origin, n_origin;
    logic [30:0] r_md, n_md;
    logic [31:0] r_aep, n_aep;
    logic [31:0] r_dsp, n_dsp;

    logic [15:0] r_snap_cruise, n_snap_cruise;
    logic [24:0] r_snap_twoa, n_snap_twoa;
    logic [31:0] r_snap_start2, n_snap_start2;
    logic [31:0] r_snap_end2, n_snap_end2;

    logic [30:0] r_dist, n_dist;
    logic [31:0] r_cr2, n_cr2;
    logic        r_neg, n_neg;
    logic [32:0] r_t, n_t;
    logic [32:0] r_sm, n_sm;
    logic [32:0] r_sa, n_sa;
    logic        r_bad, n_bad;
    logic [31:0] r_qadd, n_qadd;
    logic [30:0] r_mop, n_mop;
    logic [55:0] r_prod, n_prod;

    logic        r_valid, n_valid;
    logic [15:0] r_speed, n_speed;
    logic [30:0] r_stop, n_stop;
    logic        r_bad_out, n_bad_out;

    tspp_pkg::t_iu_req iu_req;
    tspp_pkg::t_iu_rsp iu_rsp;

    logic [32:0] pos_ext, tgt_ext, origin_ext;
    logic [23:0] a_eff;
    logic [24:0] mul_a;
    logic [30:0] mul_b;
    logic [55:0] mul_p;

    logic [32:0] ad_a, ad_b;
    logic [33:0] ad_diff, ad_neg, ad_mag;
    logic [30:0] dist_sat;

    logic [31:0] num_hi;
    logic [32:0] num_diff, num_neg;
    logic [31:0] num_mag;

    logic [32:0] t_sum, sm_tmp, sm_val, sa_val;
    logic        bad_val, sa_lt_sm;
    logic [33:0] dsp_full;
    logic [31:0] dsp_sat;

    logic        s_lt_aep, s_lt_dsp, s_lt_md;
    logic [30:0] tail;
    logic [56:0] qsum;

    logic [30:0] md_a, r_a, md_b, r_b, r_c;
    logic [32:0] sum_b;
    logic [31:0] rem_c;

    assign pos_ext = {{(33 - POSITION_BITS){i_position[POSITION_BITS-1]}},
                      i_position[POSITION_BITS-1:0]};
    assign tgt_ext = {{(33 - POSITION_BITS){i_target_position[POSITION_BITS-1]}},
                      i_target_position[POSITION_BITS-1:0]};
    assign origin_ext = {{(33 - POSITION_BITS){r_origin[POSITION_BITS-1]}}, r_origin};
    assign a_eff = (r_accel == 24'd0) ? 24'd1 : r_accel;

    assign busy = (r_state != tspp_pkg::ST_IDLE);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            tspp_pkg::ST_DIST: begin
                mul_a = {9'd0, r_start_spd};
                mul_b = {15'd0, r_start_spd};
            end
            tspp_pkg::ST_SQ_END: begin
                mul_a = {9'd0, r_end_spd};
                mul_b = {15'd0, r_end_spd};
            end
            tspp_pkg::ST_SQ_CRUISE: begin
                mul_a = {9'd0, r_snap_cruise};
                mul_b = {15'd0, r_snap_cruise};
            end
            tspp_pkg::ST_QMUL: begin
                mul_a = r_snap_twoa;
                mul_b = r_mop;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        ad_a     = (r_cmd == tspp_pkg::CMD_PLAN) ? r_tgt : r_pos;
        ad_b     = (r_cmd == tspp_pkg::CMD_PLAN) ? r_pos : origin_ext;
        ad_diff  = {ad_a[32], ad_a} - {ad_b[32], ad_b};
        ad_neg   = -ad_diff;
        ad_mag   = ad_diff[33] ? ad_neg : ad_diff;
        dist_sat = (|ad_mag[33:31]) ? tspp_pkg::DIST_MAX : ad_mag[30:0];

        num_hi   = (r_state == tspp_pkg::ST_DIV2_GO) ? r_cr2 : r_snap_end2;
        num_diff = {1'b0, num_hi} - {1'b0, r_snap_start2};
        num_neg  = -num_diff;
        num_mag  = num_diff[32] ? num_neg[31:0] : num_diff[31:0];

        t_sum    = r_neg ? ({2'b00, r_dist} - {1'b0, iu_rsp.q})
                         : ({2'b00, r_dist} + {1'b0, iu_rsp.q});
        sm_tmp   = r_t + {32'd0, r_t[32]};
        sm_val   = {sm_tmp[32], sm_tmp[32:1]};
        sa_val   = r_neg ? (33'd0 - {1'b0, iu_rsp.q}) : {1'b0, iu_rsp.q};
        bad_val  = r_sm[32] | (r_sm[31:0] > {1'b0, r_dist});
        sa_lt_sm = $signed(r_sa) < $signed(r_sm);
        dsp_full = {r_sm, 1'b0} - {r_sa[32], r_sa};
        dsp_sat  = (|dsp_full[33:31]) ? {1'b0, tspp_pkg::DIST_MAX} : dsp_full[31:0];

        s_lt_aep = $signed({1'b0, r_dist}) < $signed(r_aep);
        s_lt_dsp = $signed({1'b0, r_dist}) < $signed(r_dsp);
        s_lt_md  = r_dist < r_md;
        tail     = r_md - r_dist - 31'd1;
        qsum     = {1'b0, r_prod} + {25'd0, r_qadd};

        md_a  = r_dist[30] ? tspp_pkg::DIST_MAX : {r_dist[29:0], 1'b0};
        r_a   = (r_dist < tspp_pkg::MIN_STOP_STEPS) ? tspp_pkg::MIN_STOP_STEPS : r_dist;
        sum_b = {2'b00, r_dist} + {r_aep[31], r_aep};
        if (sum_b[32]) begin
            md_b = '0;
        end else if (sum_b[31]) begin
            md_b = tspp_pkg::DIST_MAX;
        end else begin
            md_b = sum_b[30:0];
        end
        r_b   = ($signed(r_aep) < $signed({1'b0, tspp_pkg::MIN_STOP_STEPS}))
                ? tspp_pkg::MIN_STOP_STEPS : r_aep[30:0];
        rem_c = {1'b0, r_md} - {1'b0, r_dist};
        if (rem_c[31] || (rem_c == 32'd0)) begin
            r_c = '0;
        end else if (rem_c[30:0] < tspp_pkg::MIN_STOP_STEPS) begin
            r_c = tspp_pkg::MIN_STOP_STEPS;
        end else begin
            r_c = rem_c[30:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tspp_pkg::ST_IDLE: begin
                if (start) n_state = tspp_pkg::ST_DIST;
            end
            tspp_pkg::ST_DIST: begin
                case (r_cmd)
                    tspp_pkg::CMD_PLAN:  n_state = tspp_pkg::ST_SQ_END;
                    tspp_pkg::CMD_SPEED: n_state = tspp_pkg::ST_QSEL;
                    tspp_pkg::CMD_STOP:  n_state = tspp_pkg::ST_STOP;
                    default:             n_state = tspp_pkg::ST_IDLE;
                endcase
            end
            tspp_pkg::ST_SQ_END:    n_state = tspp_pkg::ST_SQ_CRUISE;
            tspp_pkg::ST_SQ_CRUISE: n_state = tspp_pkg::ST_DIV1_GO;
            tspp_pkg::ST_DIV1_GO:   n_state = tspp_pkg::ST_DIV1_WAIT;
            tspp_pkg::ST_DIV1_WAIT: begin
                if (iu_rsp.done) n_state = tspp_pkg::ST_DIV2_GO;
            end
            tspp_pkg::ST_DIV2_GO:   n_state = tspp_pkg::ST_DIV2_WAIT;
            tspp_pkg::ST_DIV2_WAIT: begin
                if (iu_rsp.done) n_state = tspp_pkg::ST_PLAN_END;
            end
            tspp_pkg::ST_PLAN_END:  n_state = tspp_pkg::ST_IDLE;
            tspp_pkg::ST_QSEL: begin
                if (s_lt_aep || (!s_lt_dsp && s_lt_md)) begin
                    n_state = tspp_pkg::ST_QMUL;
                end else begin
                    n_state = tspp_pkg::ST_IDLE;
                end
            end
            tspp_pkg::ST_QMUL: n_state = tspp_pkg::ST_QADD;
            tspp_pkg::ST_QADD: begin
                n_state = (|qsum[56:32]) ? tspp_pkg::ST_IDLE : tspp_pkg::ST_SQ_WAIT;
            end
            tspp_pkg::ST_SQ_WAIT: begin
                if (iu_rsp.done) n_state = tspp_pkg::ST_IDLE;
            end
            tspp_pkg::ST_STOP: n_state = tspp_pkg::ST_IDLE;
            default:           n_state = tspp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd         = r_cmd;
        n_pos         = r_pos;
        n_tgt         = r_tgt;
        n_origin      = r_origin;
        n_md          = r_md;
        n_aep         = r_aep;
        n_dsp         = r_dsp;
        n_snap_cruise = r_snap_cruise;
        n_snap_twoa   = r_snap_twoa;
        n_snap_start2 = r_snap_start2;
        n_snap_end2   = r_snap_end2;
        n_dist        = r_dist;
        n_cr2         = r_cr2;
        n_neg         = r_neg;
        n_t           = r_t;
        n_sm          = r_sm;
        n_sa          = r_sa;
        n_bad         = r_bad;
        n_qadd        = r_qadd;
        n_mop         = r_mop;
        n_prod        = r_prod;
        n_valid       = 1'b0;
        n_speed       = r_speed;
        n_stop        = r_stop;
        n_bad_out     = r_bad_out;
        iu_req        = '0;
        case (r_state)
            tspp_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    n_pos = pos_ext;
                    n_tgt = tgt_ext;
                    if (i_command == tspp_pkg::CMD_PLAN) begin
                        n_snap_cruise = r_cruise;
                        n_snap_twoa   = {a_eff, 1'b0};
                    end
                end
            end
            tspp_pkg::ST_DIST: begin
                n_dist = dist_sat;
                if (r_cmd == tspp_pkg::CMD_PLAN) begin
                    n_snap_start2 = mul_p[31:0];
                end
                if (r_cmd != tspp_pkg::CMD_PLAN && r_cmd != tspp_pkg::CMD_SPEED &&
                    r_cmd != tspp_pkg::CMD_STOP) begin
                    n_valid   = 1'b1;
                    n_speed   = '0;
                    n_stop    = '0;
                    n_bad_out = 1'b0;
                end
            end
            tspp_pkg::ST_SQ_END: begin
                n_snap_end2 = mul_p[31:0];
            end
            tspp_pkg::ST_SQ_CRUISE: begin
                n_cr2 = mul_p[31:0];
            end
            tspp_pkg::ST_DIV1_GO, tspp_pkg::ST_DIV2_GO: begin
                iu_req.go  = 1'b1;
                iu_req.op  = tspp_pkg::IU_DIV;
                iu_req.num = num_mag;
                iu_req.den = r_snap_twoa;
                n_neg      = num_diff[32];
                if (r_state == tspp_pkg::ST_DIV2_GO) begin
                    n_sm = sm_val;
                end
            end
            tspp_pkg::ST_DIV1_WAIT: begin
                if (iu_rsp.done) n_t = t_sum;
            end
            tspp_pkg::ST_DIV2_WAIT: begin
                if (iu_rsp.done) begin
                    n_sa  = sa_val;
                    n_bad = bad_val;
                end
            end
            tspp_pkg::ST_PLAN_END: begin
                n_origin = r_pos[POSITION_BITS-1:0];
                n_md     = r_dist;
                if (r_bad) begin
                    n_aep = {1'b0, r_dist};
                    n_dsp = {1'b0, r_dist};
                end else if (sa_lt_sm) begin
                    n_aep = r_sa[31:0];
                    n_dsp = dsp_sat;
                end else begin
                    n_aep = r_sm[31:0];
                    n_dsp = r_sm[31:0];
                end
                n_valid   = 1'b1;
                n_speed   = r_start_spd;
                n_stop    = '0;
                n_bad_out = r_bad;
            end
            tspp_pkg::ST_QSEL: begin
                n_stop    = '0;
                n_bad_out = 1'b0;
                if (s_lt_aep) begin
                    n_mop  = r_dist;
                    n_qadd = r_snap_start2;
                end else if (s_lt_dsp) begin
                    n_valid = 1'b1;
                    n_speed = r_snap_cruise;
                end else if (s_lt_md) begin
                    n_mop  = tail;
                    n_qadd = r_snap_end2;
                end else begin
                    n_valid = 1'b1;
                    n_speed = '0;
                end
            end
            tspp_pkg::ST_QMUL: begin
                n_prod = mul_p;
            end
            tspp_pkg::ST_QADD: begin
                if (|qsum[56:32]) begin
                    n_valid = 1'b1;
                    n_speed = tspp_pkg::SPEED_MAX;
                end else begin
                    iu_req.go  = 1'b1;
                    iu_req.op  = tspp_pkg::IU_SQRT;
                    iu_req.num = qsum[31:0];
                    iu_req.den = '0;
                end
            end
            tspp_pkg::ST_SQ_WAIT: begin
                if (iu_rsp.done) begin
                    n_valid = 1'b1;
                    n_speed = iu_rsp.q[15:0];
                end
            end
            tspp_pkg::ST_STOP: begin
                n_valid   = 1'b1;
                n_speed   = '0;
                n_bad_out = 1'b0;
                if (s_lt_aep) begin
                    n_aep  = '0;
                    n_dsp  = '0;
                    n_md   = md_a;
                    n_stop = r_a;
                end else if (s_lt_dsp) begin
                    n_dsp  = '0;
                    n_md   = md_b;
                    n_stop = r_b;
                end else begin
                    n_stop = r_c;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    tspp_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iu_req),
        .o_rsp   (iu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tspp_pkg::ST_IDLE;
            r_valid       <= 1'b0;
            r_cruise      <= tspp_pkg::CRUISE_RST;
            r_start_spd   <= tspp_pkg::START_RST;
            r_end_spd     <= tspp_pkg::END_RST;
            r_accel       <= tspp_pkg::ACCEL_RST;
            r_origin      <= '0;
            r_md          <= '0;
            r_aep         <= '0;
            r_dsp         <= '0;
            r_snap_cruise <= tspp_pkg::CRUISE_RST;
            r_snap_twoa   <= tspp_pkg::TWOA_RST;
            r_snap_start2 <= tspp_pkg::SQ_RST;
            r_snap_end2   <= tspp_pkg::SQ_RST;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_origin      <= n_origin;
            r_md          <= n_md;
            r_aep         <= n_aep;
            r_dsp         <= n_dsp;
            r_snap_cruise <= n_snap_cruise;
            r_snap_twoa   <= n_snap_twoa;
            r_snap_start2 <= n_snap_start2;
            r_snap_end2   <= n_snap_end2;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tspp_pkg::REG_CRUISE: r_cruise    <= i_cfg_data[15:0];
                    tspp_pkg::REG_START:  r_start_spd <= i_cfg_data[15:0];
                    tspp_pkg::REG_END:    r_end_spd   <= i_cfg_data[15:0];
                    tspp_pkg::REG_ACCEL:  r_accel     <= i_cfg_data;
                    default:              r_accel     <= r_accel;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_pos     <= n_pos;
        r_tgt     <= n_tgt;
        r_dist    <= n_dist;
        r_cr2     <= n_cr2;
        r_neg     <= n_neg;
        r_t       <= n_t;
        r_sm      <= n_sm;
        r_sa      <= n_sa;
        r_bad     <= n_bad;
        r_qadd    <= n_qadd;
        r_mop     <= n_mop;
        r_prod    <= n_prod;
        r_speed   <= n_speed;
        r_stop    <= n_stop;
        r_bad_out <= n_bad_out;
    end

    assign o_valid      = r_valid;
    assign o_speed      = r_speed;
    assign o_stop_steps = r_stop;
    assign o_bad_input  = r_bad_out;

`ifndef SYNTHESIS
    a_valid_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a command is still in work");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    a_unit_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iu_rsp.done |-> (r_state == tspp_pkg::ST_DIV1_WAIT ||
                         r_state == tspp_pkg::ST_DIV2_WAIT ||
                         r_state == tspp_pkg::ST_SQ_WAIT))
        else $error("shared unit finished outside a wait state");
`endif

endmodule

>>> rtl/tspp_iter_unit.sv
// Shared restoring divider / integer square root, one digit per cycle.
// Divide: 32-bit by 25-bit. Root: 32-bit radicand.
// Depends on tspp_pkg.
module tspp_iter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tspp_pkg::t_iu_req i_req,
    output tspp_pkg::t_iu_rsp o_rsp
);

    logic [31:0]      r_acc, n_acc;
    logic [25:0]      r_rem, n_rem;
    logic [31:0]      r_q, n_q;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    tspp_pkg::t_iu_op r_op, n_op;
    logic [24:0]      r_den, n_den;

    logic [25:0] shifted;
    logic [25:0] trial;
    logic [26:0] diff;
    logic        ge;

    always_comb begin
        if (r_op == tspp_pkg::IU_SQRT) begin
            shifted = {r_rem[23:0], r_acc[31:30]};
            trial   = {8'd0, r_q[15:0], 2'b01};
        end else begin
            shifted = {r_rem[24:0], r_acc[31]};
            trial   = {1'b0, r_den};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[26];
    end

    always_comb begin
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_den  = r_den;
        if (i_req.go) begin
            n_acc  = i_req.num;
            n_rem  = '0;
            n_q    = '0;
            n_op   = i_req.op;
            n_den  = i_req.den;
            n_busy = 1'b1;
            n_cnt  = (i_req.op == tspp_pkg::IU_SQRT) ? tspp_pkg::SQRT_STEPS
                                                     : tspp_pkg::DIV_STEPS;
        end else if (r_busy) begin
            n_rem = ge ? diff[25:0] : shifted;
            n_acc = (r_op == tspp_pkg::IU_SQRT) ? {r_acc[29:0], 2'b00}
                                                : {r_acc[30:0], 1'b0};
            n_q   = {r_q[30:0], ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_op  <= n_op;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

>>> tb/tspp_result_checker.sv
// Result checker for the trapezoidal step speed planner: follows register writes and
// accepted command beats, predicts each result and compares it with the strobed output.
// Depends on tspp_pkg; instantiated beside the block by tb_trapezoidal_step_speed_planner_unit.
module tspp_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_position,
    input  logic [31:0] i_target_position,
    input  logic        i_valid,
    input  logic [15:0] i_speed,
    input  logic [30:0] i_stop_steps,
    input  logic        i_bad_input,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import tspp_pkg::*;

    localparam longint SPAN_LIMIT = longint'(DIST_MAX);
    localparam longint STOP_FLOOR = longint'(MIN_STOP_STEPS);

    typedef struct packed {
        logic [15:0] speed;
        logic [30:0] stop_steps;
        logic        bad_input;
    } t_outcome;

    t_outcome    pending_outcomes[$];
    logic [15:0] cruise_reg, start_reg, end_reg;
    logic [23:0] accel_reg;
    longint      snap_cruise, snap_start_sq, snap_end_sq, snap_two_accel;
    longint      origin, distance, ramp_end, brake_start;

    initial begin
        o_mismatches = 0;
        o_checked = 0;
        o_outstanding = 0;
    end

    function automatic longint span(input longint a, input longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        return (d > SPAN_LIMIT) ? SPAN_LIMIT : d;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_span(input longint v);
        if (v < 0) return 0;
        return (v > SPAN_LIMIT) ? SPAN_LIMIT : v;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [15:0] clip16(input longint unsigned v);
        return (v > 64'd65535) ? SPEED_MAX : v[15:0];
    endfunction

    function automatic t_outcome planner_outcome(input logic [1:0] cmd,
                                                 input logic [31:0] pos_raw,
                                                 input logic [31:0] tgt_raw);
        t_outcome res;
        longint   pos, tgt, a, mid, ramp, s, r;
        res = '0;
        pos = longint'($signed(pos_raw));
        tgt = longint'($signed(tgt_raw));
        case (cmd)
            CMD_PLAN: begin
                a = (accel_reg == '0) ? 1 : longint'(accel_reg);
                snap_cruise = longint'(cruise_reg);
                snap_start_sq = longint'(start_reg) * longint'(start_reg);
                snap_end_sq = longint'(end_reg) * longint'(end_reg);
                snap_two_accel = 2 * a;
                origin = pos;
                distance = span(tgt, pos);
                mid = ((snap_end_sq - snap_start_sq) / snap_two_accel + distance) / 2;
                if (mid >= 0 && mid <= distance) begin
                    ramp = (snap_cruise * snap_cruise - snap_start_sq) / snap_two_accel;
                    if (ramp < mid) begin
                        ramp_end = clip32(ramp);
                        brake_start = clip32(2 * mid - ramp);
                    end else begin
                        ramp_end = mid;
                        brake_start = mid;
                    end
                end else begin
                    res.bad_input = 1'b1;
                    ramp_end = distance;
                    brake_start = distance;
                end
                res.speed = start_reg;
            end
            CMD_SPEED: begin
                s = span(pos, origin);
                if (s < ramp_end)
                    res.speed = clip16(floor_root(snap_two_accel * s + snap_start_sq));
                else if (s < brake_start)
                    res.speed = snap_cruise[15:0];
                else if (s < distance)
                    res.speed = clip16(floor_root(snap_two_accel * (distance - s - 1)
                                                  + snap_end_sq));
            end
            CMD_STOP: begin
                s = span(pos, origin);
                if (s < ramp_end) begin
                    ramp_end = 0;
                    brake_start = 0;
                    distance = clip_span(2 * s);
                    r = (s < STOP_FLOOR) ? STOP_FLOOR : s;
                end else if (s < brake_start) begin
                    brake_start = 0;
                    distance = clip_span(s + ramp_end);
                    r = (ramp_end < STOP_FLOOR) ? STOP_FLOOR : ramp_end;
                end else begin
                    r = distance - s;
                    r = (r > 0) ? ((r < STOP_FLOOR) ? STOP_FLOOR : r) : 0;
                end
                res.stop_steps = r[30:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic complain(input string msg);
        o_mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            pending_outcomes.delete();
            cruise_reg = CRUISE_RST;
            start_reg = START_RST;
            end_reg = END_RST;
            accel_reg = ACCEL_RST;
            snap_cruise = longint'(CRUISE_RST);
            snap_start_sq = longint'(SQ_RST);
            snap_end_sq = longint'(SQ_RST);
            snap_two_accel = longint'(TWOA_RST);
            origin = 0;
            distance = 0;
            ramp_end = 0;
            brake_start = 0;
        end else begin
            if (i_valid) begin
                got = {i_speed, i_stop_steps, i_bad_input};
                if (pending_outcomes.size() == 0) begin
                    complain($sformatf("result with nothing expected: speed %0d stop %0d bad %0b",
                                       got.speed, got.stop_steps, got.bad_input));
                end else begin
                    want = pending_outcomes.pop_front();
                    o_checked++;
                    if (got.speed != want.speed)
                        complain($sformatf("speed %0d, expected %0d", got.speed, want.speed));
                    if (got.stop_steps != want.stop_steps)
                        complain($sformatf("stop_steps %0d, expected %0d",
                                           got.stop_steps, want.stop_steps));
                    if (got.bad_input != want.bad_input)
                        complain($sformatf("bad_input %0b, expected %0b",
                                           got.bad_input, want.bad_input));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CRUISE: cruise_reg = i_cfg_data[15:0];
                    REG_START:  start_reg = i_cfg_data[15:0];
                    REG_END:    end_reg = i_cfg_data[15:0];
                    REG_ACCEL:  accel_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                pending_outcomes.push_back(planner_outcome(i_command, i_position,
                                                           i_target_position));
        end
        o_outstanding <= pending_outcomes.size();
    end

endmodule

>>> tb/tb_trapezoidal_step_speed_planner_unit.sv
// Testbench top for trapezoidal_step_speed_planner_unit: drives command beats and
// register profiles, and gives the verdict from the counts of tspp_result_checker.
// Depends on tspp_pkg, trapezoidal_step_speed_planner_unit and tspp_result_checker.
module tb_trapezoidal_step_speed_planner_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tspp_pkg::*;

    localparam logic [1:0] CMD_UNDEF = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_CRUISE;
    logic [23:0] i_cfg_data = '0;
    logic [1:0]  i_command = CMD_PLAN;
    logic [31:0] i_position = '0;
    logic [31:0] i_target_position = '0;
    logic        o_valid;
    logic [15:0] o_speed;
    logic [30:0] o_stop_steps;
    logic        o_bad_input;

    int mismatches, outstanding, checked;
    int idle_pct = 0;
    int n_items = 0, n_plans = 0, n_queries = 0, n_stops = 0, n_undef = 0, n_profiles = 0;

    trapezoidal_step_speed_planner_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_position        (i_position),
        .i_target_position (i_target_position),
        .o_valid           (o_valid),
        .o_speed           (o_speed),
        .o_stop_steps      (o_stop_steps),
        .o_bad_input       (o_bad_input)
    );

    tspp_result_checker u_result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_position        (i_position),
        .i_target_position (i_target_position),
        .i_valid           (o_valid),
        .i_speed           (o_speed),
        .i_stop_steps      (o_stop_steps),
        .i_bad_input       (o_bad_input),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_checked         (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d results still outstanding", outstanding);
        $display("== FAIL ==");
        $finish;
    end

    task automatic issue(input logic [1:0] cmd, input logic [31:0] pos, input logic [31:0] tgt);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 90);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_position <= pos;
        i_target_position <= tgt;
        do @(posedge i_clk); while (busy);
        case (cmd)
            CMD_PLAN:  n_plans++;
            CMD_SPEED: n_queries++;
            CMD_STOP:  n_stops++;
            default:   n_undef++;
        endcase
        if (cmd != CMD_UNDEF) n_items++;
    endtask

    // drain: hold start low until every expected beat has come back
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0 || busy);
    endtask

    task automatic load_profile(input logic [15:0] cr, input logic [15:0] st,
                                input logic [15:0] en, input logic [23:0] ac);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_CRUISE;
        i_cfg_data <= {8'($urandom), cr};
        @(posedge i_clk);
        i_cfg_idx <= REG_START;
        i_cfg_data <= {8'($urandom), st};
        @(posedge i_clk);
        i_cfg_idx <= REG_END;
        i_cfg_data <= {8'($urandom), en};
        @(posedge i_clk);
        i_cfg_idx <= REG_ACCEL;
        i_cfg_data <= ac;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_profiles++;
    endtask

    function automatic logic [31:0] near(input logic [31:0] org, input int unsigned move_len);
        int unsigned s;
        case ($urandom_range(3))
            0: s = $urandom_range(0, 8);
            1: s = (move_len > 8) ? move_len - $urandom_range(0, 8) : $urandom_range(0, 8);
            default: s = $urandom_range(0, move_len + 8);
        endcase
        return $urandom_range(1) ? org + s : org - s;
    endfunction

    task automatic run_move();
        logic [31:0] org, tgt;
        int unsigned move_len;
        int          pick;
        org = $urandom;
        pick = $urandom_range(9);
        if (pick < 4) move_len = $urandom_range(0, 64);
        else if (pick < 8) move_len = $urandom_range(0, 4000);
        else if (pick < 9) move_len = $urandom_range(0, 1000000);
        else move_len = $urandom_range(0, 32'h7FFF_FFFF);
        tgt = $urandom_range(1) ? org + move_len : org - move_len;
        issue(CMD_PLAN, org, tgt);
        repeat ($urandom_range(2, 12)) issue(CMD_SPEED, near(org, move_len), $urandom);
        if ($urandom_range(99) < 35) begin
            issue(CMD_STOP, near(org, move_len), $urandom);
            repeat ($urandom_range(0, 4)) issue(CMD_SPEED, near(org, move_len), $urandom);
        end
    endtask

    task automatic random_phase(input int pct, input int count);
        int goal;
        idle_pct = pct;
        goal = n_items + count;
        while (n_items < goal) begin
            if ($urandom_range(99) < 85) run_move();
            else issue(2'($urandom_range(3)), $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(CMD_PLAN, 32'd0, 32'd1000);
        issue(CMD_SPEED, 32'd0, 32'hFFFF_FFFF);
        issue(CMD_SPEED, 32'd500, 32'd0);
        issue(CMD_SPEED, 32'(-999), 32'd0);
        issue(CMD_SPEED, 32'd1000, 32'd0);
        issue(CMD_STOP, 32'd300, 32'd0);
        issue(CMD_PLAN, 32'd100, 32'(-900));
        issue(CMD_STOP, 32'(-400), 32'd0);
        issue(CMD_PLAN, 32'd0, 32'd1000);
        issue(CMD_STOP, 32'd800, 32'd0);
        issue(CMD_STOP, 32'd2000, 32'd0);
        issue(CMD_PLAN, 32'd0, 32'd1000);
        issue(CMD_STOP, 32'd2, 32'd0);
        issue(CMD_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(CMD_PLAN, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(CMD_SPEED, 32'h7FFF_FFFF, 32'd0);
        issue(CMD_STOP, 32'h0000_1000, 32'd0);
        issue(CMD_PLAN, 32'd5, 32'd5);
        issue(CMD_SPEED, 32'd5, 32'd0);
        settle();

        load_profile(CRUISE_RST, START_RST, 16'd3000, ACCEL_RST);
        issue(CMD_PLAN, 32'd0, 32'd10);
        issue(CMD_SPEED, 32'd3, 32'd0);
        issue(CMD_STOP, 32'(-3), 32'd0);
        settle();

        load_profile(16'd50, 16'd400, 16'd400, 24'd0);
        issue(CMD_PLAN, 32'd0, 32'd100);
        issue(CMD_SPEED, 32'd20, 32'd0);
        issue(CMD_STOP, 32'd20, 32'd0);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_profile(CRUISE_RST, START_RST, END_RST, ACCEL_RST);
                1: load_profile(16'hFFFF, 16'd0, 16'd0, 24'hFF_FFFF);
                2: load_profile(16'd50, 16'd400, 16'd30, 24'd0);
                3: load_profile(16'($urandom), 16'($urandom_range(0, 3000)),
                                16'($urandom_range(0, 3000)), 24'($urandom_range(1, 200000)));
                4: load_profile(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd1);
                default: load_profile(16'd0, 16'd0, 16'd3000, 24'd500);
            endcase
            random_phase((p < 2) ? 19 : (p < 4) ? 60 : 0, 170);
            settle();
        end
        repeat (80) @(posedge i_clk);

        $display("ran %0d commands over %0d register profiles: %0d plans, %0d speed queries,",
                 n_items + n_undef, n_profiles, n_plans, n_queries);
        $display("%0d stops, %0d undefined; %0d results checked, %0d mismatches",
                 n_stops, n_undef, checked, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/tspp_pkg.sv
rtl/tspp_iter_unit.sv
rtl/trapezoidal_step_speed_planner_unit.sv
tb/tspp_result_checker.sv
tb/tb_trapezoidal_step_speed_planner_unit.sv
